[rtl/bft_pkg.sv]
// Shared types and constants of the bidirectional flow table.
`timescale 1ns / 1ps
`default_nettype none

package bft_pkg;

    typedef enum logic [2:0] {
        FUNC_PACKET = 3'd0,
        FUNC_TICK   = 3'd1,
        FUNC_SWEEP  = 3'd2,
        FUNC_CLOSE  = 3'd3,
        FUNC_READ   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_ACTIVE = 2'd0,
        ST_IDLE   = 2'd1,
        ST_CLOSED = 2'd2
    } flow_state_t;

    localparam logic [19:0] TIMEOUT_RESET = 20'd300;

    // Packet status codes that bump a counter.
    localparam logic [1:0] PSTAT_RETRANS = 2'd1;
    localparam logic [1:0] PSTAT_ERROR   = 2'd2;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  proto;
        flow_state_t state;
        logic [47:0] bytes;
        logic [31:0] pkts;
        logic [31:0] retr;
        logic [31:0] errs;
        logic [39:0] lat;
        logic [31:0] last;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        WR_NONE,
        WR_HIT,
        WR_NEW,
        WR_SWEEP,
        WR_CLOSE
    } wr_sel_t;

    typedef enum logic [2:0] {
        HOLD_NONE,
        HOLD_HIT,
        HOLD_NEW,
        HOLD_REJ,
        HOLD_CLOSE,
        HOLD_READ
    } hold_sel_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_DECODE,
        CS_READ,
        CS_EVAL,
        CS_NEW,
        CS_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic      latch;
        logic      ptr_zero;
        logic      ptr_id;
        logic      ptr_inc;
        logic      rd_en;
        wr_sel_t   wr_sel;
        logic      hold_load;
        hold_sel_t hold_sel;
        logic      tick;
        logic      out_load;
    } bft_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       matched;
        logic       last;
        logic       full;
        logic       used_zero;
        logic       id_ok;
        logic       out_busy;
    } bft_status_t;

endpackage

`default_nettype wire

[rtl/bft_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none

module bft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/bft_ctrl.sv]
// Sequencing state machine of the flow table.
`timescale 1ns / 1ps
`default_nettype none

module bft_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire bft_pkg::bft_status_t status,
    output bft_pkg::bft_cmd_t         cmd
);
    import bft_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != CS_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.wr_sel   = WR_NONE;
        cmd.hold_sel = HOLD_NONE;
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = CS_DECODE;
                end
            end
            CS_DECODE:
            begin
                case (func_t'(status.func))
                    FUNC_PACKET:
                    begin
                        if (status.used_zero)
                        begin
                            state_next = CS_NEW;
                        end
                        else
                        begin
                            cmd.ptr_zero = 1'b1;
                            state_next   = CS_READ;
                        end
                    end
                    FUNC_TICK:
                    begin
                        cmd.tick      = 1'b1;
                        cmd.hold_load = 1'b1;
                        state_next    = CS_OUT;
                    end
                    FUNC_SWEEP:
                    begin
                        if (status.used_zero)
                        begin
                            cmd.hold_load = 1'b1;
                            state_next    = CS_OUT;
                        end
                        else
                        begin
                            cmd.ptr_zero = 1'b1;
                            state_next   = CS_READ;
                        end
                    end
                    FUNC_CLOSE, FUNC_READ:
                    begin
                        if (status.id_ok)
                        begin
                            cmd.ptr_id = 1'b1;
                            state_next = CS_READ;
                        end
                        else
                        begin
                            cmd.hold_load = 1'b1;
                            state_next    = CS_OUT;
                        end
                    end
                    default:
                    begin
                        cmd.hold_load = 1'b1;
                        state_next    = CS_OUT;
                    end
                endcase
            end
            CS_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = CS_EVAL;
            end
            CS_EVAL:
            begin
                case (func_t'(status.func))
                    FUNC_PACKET:
                    begin
                        if (status.matched)
                        begin
                            cmd.wr_sel    = WR_HIT;
                            cmd.hold_load = 1'b1;
                            cmd.hold_sel  = HOLD_HIT;
                            state_next    = CS_OUT;
                        end
                        else if (status.last)
                        begin
                            if (status.full)
                            begin
                                cmd.hold_load = 1'b1;
                                cmd.hold_sel  = HOLD_REJ;
                                state_next    = CS_OUT;
                            end
                            else
                            begin
                                state_next = CS_NEW;
                            end
                        end
                        else
                        begin
                            cmd.ptr_inc = 1'b1;
                            state_next  = CS_READ;
                        end
                    end
                    FUNC_SWEEP:
                    begin
                        cmd.wr_sel = WR_SWEEP;
                        if (status.last)
                        begin
                            cmd.hold_load = 1'b1;
                            state_next    = CS_OUT;
                        end
                        else
                        begin
                            cmd.ptr_inc = 1'b1;
                            state_next  = CS_READ;
                        end
                    end
                    FUNC_CLOSE:
                    begin
                        cmd.wr_sel    = WR_CLOSE;
                        cmd.hold_load = 1'b1;
                        cmd.hold_sel  = HOLD_CLOSE;
                        state_next    = CS_OUT;
                    end
                    default:
                    begin
                        cmd.hold_load = 1'b1;
                        cmd.hold_sel  = HOLD_READ;
                        state_next    = CS_OUT;
                    end
                endcase
            end
            CS_NEW:
            begin
                cmd.wr_sel    = WR_NEW;
                cmd.hold_load = 1'b1;
                cmd.hold_sel  = HOLD_NEW;
                state_next    = CS_OUT;
            end
            CS_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // A result is only presented after the item has been decoded.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> state_reg == CS_OUT)
        else $error("result loaded outside the output state");

    // A write is only issued from an evaluate or append step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_sel != WR_NONE) |-> (state_reg == CS_EVAL || state_reg == CS_NEW))
        else $error("table write outside evaluate or append");

    // Every evaluate step follows a read of the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == CS_EVAL |-> $past(cmd.rd_en))
        else $error("evaluate without a preceding read");

endmodule

`default_nettype wire

[rtl/bft_datapath.sv]
// Entry storage, counters, match and update logic, and result register.
`timescale 1ns / 1ps
`default_nettype none

module bft_datapath #(
    parameter int MAX_ENTRIES = 256
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bft_pkg::bft_cmd_t    cmd,
    output bft_pkg::bft_status_t      status,
    input  wire logic                 cfg_we,
    input  wire logic [19:0]          cfg_wdata,
    input  wire logic [2:0]           func,
    input  wire logic [31:0]          src_id,
    input  wire logic [31:0]          dst_id,
    input  wire logic [7:0]           protocol,
    input  wire logic [15:0]          pkt_size,
    input  wire logic [15:0]          pkt_latency,
    input  wire logic [1:0]           pkt_status,
    input  wire logic [8:0]           session_id,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [8:0]                result_id,
    output logic                      created,
    output logic                      rejected,
    output logic [1:0]                entry_state,
    output logic [47:0]               byte_count,
    output logic [31:0]               packet_count,
    output logic [31:0]               retransmit_count,
    output logic [31:0]               error_count,
    output logic [39:0]               latency_sum,
    output logic [8:0]                entry_count,
    output logic [8:0]                active_count
);
    import bft_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // Latched item.
    logic [2:0]  func_reg;
    logic [31:0] src_reg;
    logic [31:0] dst_reg;
    logic [7:0]  proto_reg;
    logic [15:0] size_reg;
    logic [15:0] lat_reg;
    logic [1:0]  pstat_reg;
    logic [8:0]  sid_reg;

    logic [IDX_W-1:0] ptr_reg;
    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] active_reg;
    logic [31:0]      now_reg;
    logic [19:0]      timeout_reg;

    logic [31:0] id_dec;
    logic [31:0] ptr_ext;
    logic [31:0] used_ext;
    logic [31:0] active_ext;
    logic [31:0] slot_id;
    logic [31:0] new_id;

    entry_t ent;
    entry_t upd;
    entry_t new_rec;
    entry_t swept;
    entry_t closed;
    entry_t wdata;
    logic [ENTRY_W-1:0] rdata;
    logic               wr_en;
    logic [IDX_W-1:0]   waddr;

    logic        matched;
    logic [48:0] bytes_sum;
    logic [32:0] pkts_sum;
    logic [32:0] retr_sum;
    logic [32:0] errs_sum;
    logic [40:0] lat_sum;
    logic [31:0] elapsed;
    logic [21:0] t3;
    logic        to_idle;
    logic        sweep_dec;
    logic        close_dec;

    entry_t      hold_reg;
    logic [8:0]  hold_id_reg;
    logic        hold_created_reg;
    logic        hold_rejected_reg;
    logic        out_valid_reg;

    // Result beat registers.
    logic [8:0]  result_id_reg;
    logic        created_reg;
    logic        rejected_reg;
    logic [1:0]  entry_state_reg;
    logic [47:0] byte_count_reg;
    logic [31:0] packet_count_reg;
    logic [31:0] retransmit_count_reg;
    logic [31:0] error_count_reg;
    logic [39:0] latency_sum_reg;
    logic [8:0]  entry_count_reg;
    logic [8:0]  active_count_reg;

    assign ent        = entry_t'(rdata);
    assign id_dec     = 32'(sid_reg) - 32'd1;
    assign ptr_ext    = 32'(ptr_reg);
    assign used_ext   = 32'(used_reg);
    assign active_ext = 32'(active_reg);
    assign slot_id    = ptr_ext + 32'd1;
    assign new_id     = used_ext + 32'd1;

    // Input latch.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg  <= func;
            src_reg   <= src_id;
            dst_reg   <= dst_id;
            proto_reg <= protocol;
            size_reg  <= pkt_size;
            lat_reg   <= pkt_latency;
            pstat_reg <= pkt_status;
            sid_reg   <= session_id;
        end
    end

    // Scan pointer.
    always_ff @(posedge clk)
    begin
        if (cmd.ptr_zero)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.ptr_id)
        begin
            ptr_reg <= id_dec[IDX_W-1:0];
        end
        else if (cmd.ptr_inc)
        begin
            ptr_reg <= ptr_reg + IDX_W'(1);
        end
    end

    // Match and saturating update of the entry just read.
    assign matched = (ent.state != ST_CLOSED) && (ent.proto == proto_reg) &&
                     ((ent.src == src_reg && ent.dst == dst_reg) ||
                      (ent.src == dst_reg && ent.dst == src_reg));

    assign bytes_sum = {1'b0, ent.bytes} + 49'(size_reg);
    assign pkts_sum  = {1'b0, ent.pkts} + 33'd1;
    assign retr_sum  = {1'b0, ent.retr} + 33'd1;
    assign errs_sum  = {1'b0, ent.errs} + 33'd1;
    assign lat_sum   = {1'b0, ent.lat} + 41'(lat_reg);

    always_comb
    begin
        upd       = ent;
        upd.bytes = bytes_sum[48] ? '1 : bytes_sum[47:0];
        upd.pkts  = pkts_sum[32] ? '1 : pkts_sum[31:0];
        upd.lat   = lat_sum[40] ? '1 : lat_sum[39:0];
        upd.last  = now_reg;
        if (pstat_reg == PSTAT_RETRANS)
        begin
            upd.retr = retr_sum[32] ? '1 : retr_sum[31:0];
        end
        if (pstat_reg == PSTAT_ERROR)
        begin
            upd.errs = errs_sum[32] ? '1 : errs_sum[31:0];
        end
    end

    always_comb
    begin
        new_rec.src   = src_reg;
        new_rec.dst   = dst_reg;
        new_rec.proto = proto_reg;
        new_rec.state = ST_ACTIVE;
        new_rec.bytes = 48'(size_reg);
        new_rec.pkts  = 32'd1;
        new_rec.retr  = '0;
        new_rec.errs  = '0;
        new_rec.lat   = 40'(lat_reg);
        new_rec.last  = now_reg;
    end

    // Aging: both steps may apply in one pass.
    assign elapsed = now_reg - ent.last;
    assign t3      = {2'b00, timeout_reg} + {1'b0, timeout_reg, 1'b0};
    assign to_idle = (ent.state == ST_ACTIVE) && (elapsed > 32'(timeout_reg));

    always_comb
    begin
        swept = ent;
        if (to_idle)
        begin
            swept.state = ST_IDLE;
        end
        if ((to_idle || ent.state == ST_IDLE) && elapsed > 32'(t3))
        begin
            swept.state = ST_CLOSED;
        end
    end

    always_comb
    begin
        closed       = ent;
        closed.state = ST_CLOSED;
    end

    assign sweep_dec = (cmd.wr_sel == WR_SWEEP) && to_idle && (active_reg != '0);
    assign close_dec = (cmd.wr_sel == WR_CLOSE) && (ent.state == ST_ACTIVE) &&
                       (active_reg != '0);

    // Table write.
    assign wr_en = (cmd.wr_sel != WR_NONE);
    assign waddr = (cmd.wr_sel == WR_NEW) ? used_reg[IDX_W-1:0] : ptr_reg;

    always_comb
    begin
        case (cmd.wr_sel)
            WR_HIT:   wdata = upd;
            WR_NEW:   wdata = new_rec;
            WR_SWEEP: wdata = swept;
            WR_CLOSE: wdata = closed;
            default:  wdata = ent;
        endcase
    end

    bft_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_ENTRIES)
    ) u_table (
        .clk  (clk),
        .we   (wr_en),
        .waddr(waddr),
        .wdata(wdata),
        .re   (cmd.rd_en),
        .raddr(ptr_reg),
        .rdata(rdata)
    );

    // Global counters and the timeout register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            active_reg  <= '0;
            now_reg     <= '0;
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            if (cmd.tick)
            begin
                now_reg <= now_reg + 32'd1;
            end
            if (cmd.wr_sel == WR_NEW)
            begin
                used_reg   <= used_reg + CNT_W'(1);
                active_reg <= active_reg + CNT_W'(1);
            end
            else if (sweep_dec || close_dec)
            begin
                active_reg <= active_reg - CNT_W'(1);
            end
        end
    end

    // Result hold, filled when the item's outcome is known.
    always_ff @(posedge clk)
    begin
        if (cmd.hold_load)
        begin
            hold_created_reg  <= 1'b0;
            hold_rejected_reg <= 1'b0;
            case (cmd.hold_sel)
                HOLD_HIT:
                begin
                    hold_reg    <= upd;
                    hold_id_reg <= slot_id[8:0];
                end
                HOLD_NEW:
                begin
                    hold_reg         <= new_rec;
                    hold_id_reg      <= new_id[8:0];
                    hold_created_reg <= 1'b1;
                end
                HOLD_REJ:
                begin
                    hold_reg          <= '0;
                    hold_id_reg       <= '0;
                    hold_rejected_reg <= 1'b1;
                end
                HOLD_CLOSE:
                begin
                    hold_reg    <= closed;
                    hold_id_reg <= slot_id[8:0];
                end
                HOLD_READ:
                begin
                    hold_reg    <= ent;
                    hold_id_reg <= slot_id[8:0];
                end
                default:
                begin
                    hold_reg    <= '0;
                    hold_id_reg <= '0;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_id_reg        <= hold_id_reg;
            created_reg          <= hold_created_reg;
            rejected_reg         <= hold_rejected_reg;
            entry_state_reg      <= hold_reg.state;
            byte_count_reg       <= hold_reg.bytes;
            packet_count_reg     <= hold_reg.pkts;
            retransmit_count_reg <= hold_reg.retr;
            error_count_reg      <= hold_reg.errs;
            latency_sum_reg      <= hold_reg.lat;
            entry_count_reg      <= used_ext[8:0];
            active_count_reg     <= active_ext[8:0];
        end
    end

    assign out_valid        = out_valid_reg;
    assign result_id        = result_id_reg;
    assign created          = created_reg;
    assign rejected         = rejected_reg;
    assign entry_state      = entry_state_reg;
    assign byte_count       = byte_count_reg;
    assign packet_count     = packet_count_reg;
    assign retransmit_count = retransmit_count_reg;
    assign error_count      = error_count_reg;
    assign latency_sum      = latency_sum_reg;
    assign entry_count      = entry_count_reg;
    assign active_count     = active_count_reg;

    always_comb
    begin
        status.func      = func_reg;
        status.matched   = matched;
        status.last      = (slot_id >= used_ext);
        status.full      = (used_ext >= 32'(MAX_ENTRIES));
        status.used_zero = (used_reg == '0);
        status.id_ok     = (sid_reg != '0) && (32'(sid_reg) <= used_ext);
        status.out_busy  = out_valid_reg && out_stall;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg <= used_reg)
        else $error("more active entries than entries");

    assert property (@(posedge clk) disable iff (!rst_n)
        used_ext <= 32'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_sel == WR_NEW) |=> used_reg == $past(used_reg) + CNT_W'(1))
        else $error("append did not advance the entry count");

endmodule

`default_nettype wire

[rtl/bidirectional_flow_table.sv]
// Top level of the bidirectional flow table with idle aging.
//
// Input channel: in_valid / in_stall carry one command beat (func and the
// packet or id fields). Output channel: out_valid / out_stall carry one
// result beat per command. A beat moves at a clock edge where valid is high
// and stall is low. cfg_we / cfg_wdata write the idle timeout; the user must
// do so only while idle, which the block does not enforce. The table is a
// single RAM of MAX_ENTRIES entries, scanned one entry at a time: each
// visit is a read step, then an evaluate step that writes it back. A packet
// scans from slot 0 until it matches, a new flow is appended after all
// entries, a sweep visits every entry, a close or read only its id's slot.
// The block handles one command at a time; the next command is taken as
// soon as the result sits in the output register, even if that result is
// still stalled. A stalled result holds its value; the block then waits
// before loading the following result.
// Reset clears the entry, active and time counters and sets the timeout to
// 300; table contents need no clearing, since only slots below the entry
// count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module bidirectional_flow_table #(
    parameter int MAX_ENTRIES = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [19:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  func,
    input  wire logic [31:0] src_id,
    input  wire logic [31:0] dst_id,
    input  wire logic [7:0]  protocol,
    input  wire logic [15:0] pkt_size,
    input  wire logic [15:0] pkt_latency,
    input  wire logic [1:0]  pkt_status,
    input  wire logic [8:0]  session_id,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [8:0]       result_id,
    output logic             created,
    output logic             rejected,
    output logic [1:0]       entry_state,
    output logic [47:0]      byte_count,
    output logic [31:0]      packet_count,
    output logic [31:0]      retransmit_count,
    output logic [31:0]      error_count,
    output logic [39:0]      latency_sum,
    output logic [8:0]       entry_count,
    output logic [8:0]       active_count
);
    import bft_pkg::*;

    // Commands from the sequencer and status back from the datapath.
    bft_cmd_t    cmd;
    bft_status_t status;

    bft_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .status  (status),
        .cmd     (cmd)
    );

    bft_datapath #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .func            (func),
        .src_id          (src_id),
        .dst_id          (dst_id),
        .protocol        (protocol),
        .pkt_size        (pkt_size),
        .pkt_latency     (pkt_latency),
        .pkt_status      (pkt_status),
        .session_id      (session_id),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_id       (result_id),
        .created         (created),
        .rejected        (rejected),
        .entry_state     (entry_state),
        .byte_count      (byte_count),
        .packet_count    (packet_count),
        .retransmit_count(retransmit_count),
        .error_count     (error_count),
        .latency_sum     (latency_sum),
        .entry_count     (entry_count),
        .active_count    (active_count)
    );

endmodule

`default_nettype wire
